// File: design/kes_pkg.sv
package kes_pkg;

	localparam int KEY_TABLE_ENTRIES = 32;
	localparam int KEY_IDX_W         = $clog2(KEY_TABLE_ENTRIES);

	localparam int KEY_W      = 3;
	localparam int SAMPLE_W   = 10;
	localparam int TIME_W     = 32;
	localparam int TIMEOUT_W  = 25;
	localparam int MODE_W     = 2;
	localparam int DEBOUNCE_W = 8;
	localparam int EVENT_W    = 4;
	localparam int OP_W       = 2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = TIMEOUT_W;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 8;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;

	localparam logic [KEY_W-1:0] KEY_NONE   = 3'd0;
	localparam logic [KEY_W-1:0] KEY_LEFT   = 3'd1;
	localparam logic [KEY_W-1:0] KEY_RIGHT  = 3'd2;
	localparam logic [KEY_W-1:0] KEY_UP     = 3'd3;
	localparam logic [KEY_W-1:0] KEY_DOWN   = 3'd4;
	localparam logic [KEY_W-1:0] KEY_SELECT = 3'd5;

	typedef enum logic [OP_W-1:0] {
		OP_POLL    = 2'd0,
		OP_RESTORE = 2'd1,
		OP_BLANK   = 2'd2
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_TEXT_OFF     = 2'd0,
		MODE_LIGHT_OFF    = 2'd1,
		MODE_SELECT_WAKE  = 2'd2
	} saver_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TIMEOUT  = 2'd0,
		CFG_MODE     = 2'd1,
		CFG_DEBOUNCE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0]  timeout_ms;
		logic [MODE_W-1:0]     saver_mode;
		logic [DEBOUNCE_W-1:0] debounce_ms;
	} kes_cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0]  held_key;
		logic [KEY_W-1:0]  raw_key;
		logic [TIME_W-1:0] change_time;
		logic [TIME_W-1:0] activity_time;
		logic              swallow_release;
		logic              saved;
		logic              text;
		logic              light;
		logic              started;
	} kes_state_t;

	typedef struct packed {
		logic signed [EVENT_W-1:0] key_event;
		logic                      text_on;
		logic                      light_on;
		logic                      saver_active;
	} kes_result_t;

	// ladder reading (top five bits) to key code
	function automatic logic [KEY_W-1:0] key_lookup(input logic [KEY_IDX_W-1:0] idx);
		logic [KEY_W-1:0] k;
		case (idx)
			5'd0:           k = KEY_RIGHT;
			5'd4:           k = KEY_UP;
			5'd9, 5'd10:    k = KEY_DOWN;
			5'd15, 5'd16:   k = KEY_LEFT;
			5'd22, 5'd23:   k = KEY_SELECT;
			default:        k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

// File: design/kes_step.sv
module kes_step (
	input  kes_pkg::kes_cfg_t               cfg,
	input  kes_pkg::kes_state_t             state_cur,
	input  logic [kes_pkg::OP_W-1:0]        operation,
	input  logic [kes_pkg::SAMPLE_W-1:0]    key_sample,
	input  logic [kes_pkg::TIME_W-1:0]      now_ms,
	output kes_pkg::kes_state_t             state_nxt,
	output kes_pkg::kes_result_t            result
);
	import kes_pkg::*;

	logic [KEY_W-1:0]          table_key;
	logic [KEY_W-1:0]          key;
	logic [TIME_W-1:0]         change_time;
	logic [TIME_W-1:0]         stable_ms;
	logic [TIME_W-1:0]         idle_ms;
	logic [TIME_W-1:0]         activity_eff;
	kes_state_t                st;
	logic signed [EVENT_W-1:0] ev;

	always_comb begin
		st = state_cur;
		ev = '0;

		table_key   = key_lookup(key_sample[SAMPLE_W-1 -: KEY_IDX_W]);
		change_time = (table_key != state_cur.raw_key) ? now_ms : state_cur.change_time;
		stable_ms   = now_ms - change_time;
		key = (stable_ms < {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.debounce_ms}) ?
			state_cur.held_key : table_key;

		// first poll after reset restores, so idle time counts from now
		activity_eff = state_cur.started ? state_cur.activity_time : now_ms;
		idle_ms      = now_ms - activity_eff;

		case (operation)
			OP_POLL: begin
				if (!st.started) begin
					st.text          = 1'b1;
					st.light         = 1'b1;
					st.saved         = 1'b0;
					st.started       = 1'b1;
					st.activity_time = now_ms;
				end
				st.change_time = change_time;
				st.raw_key     = table_key;

				if (state_cur.held_key == KEY_NONE && key != KEY_NONE) begin
					st.held_key        = key;
					st.swallow_release = 1'b0;
					ev                 = signed'({1'b0, key});
					if (st.saved) begin
						case (cfg.saver_mode)
							MODE_SELECT_WAKE: begin
								if (key == KEY_SELECT) begin
									st.light = 1'b1;
									st.saved = 1'b0;
								end
								st.activity_time = now_ms;
							end
							MODE_TEXT_OFF: begin
								// waking press and its release are swallowed
								st.text            = 1'b1;
								st.light           = 1'b1;
								st.saved           = 1'b0;
								st.activity_time   = now_ms;
								st.swallow_release = 1'b1;
								ev                 = '0;
							end
							default: begin
								st.text          = 1'b1;
								st.light         = 1'b1;
								st.saved         = 1'b0;
								st.activity_time = now_ms;
							end
						endcase
					end else if (!(cfg.saver_mode == MODE_SELECT_WAKE && key != KEY_SELECT)) begin
						st.activity_time = now_ms;
					end
				end else if (state_cur.held_key != KEY_NONE && key == KEY_NONE) begin
					ev = state_cur.swallow_release ? '0 :
						-signed'({1'b0, state_cur.held_key});
					st.held_key        = KEY_NONE;
					st.activity_time   = now_ms;
					st.swallow_release = 1'b0;
				end else if (!st.saved && state_cur.held_key == KEY_NONE &&
					cfg.timeout_ms != '0 &&
					idle_ms >= {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.timeout_ms}) begin
					if (cfg.saver_mode == MODE_TEXT_OFF)
						st.text = 1'b0;
					st.light = 1'b0;
					st.saved = 1'b1;
				end
			end
			OP_RESTORE: begin
				st.text          = 1'b1;
				st.light         = 1'b1;
				st.saved         = 1'b0;
				st.started       = 1'b1;
				st.activity_time = now_ms;
			end
			OP_BLANK: begin
				if (cfg.saver_mode == MODE_TEXT_OFF)
					st.text = 1'b0;
				st.light   = 1'b0;
				st.saved   = 1'b1;
				st.started = 1'b1;
			end
			default: ;
		endcase

		state_nxt           = st;
		result.key_event    = ev;
		result.text_on      = st.text;
		result.light_on     = st.light;
		result.saver_active = st.saved;
	end

endmodule

// File: design/keypad_event_screen_saver.sv
// Channel   Dir  tdata (low bit up)                 tuser
// s_axis    in   key_sample[9:0], now_ms[41:10]     operation[1:0]
// m_axis    out  key_event[3:0] (signed), text_on,  -
//                light_on, saver_active, pad
// cfg       in   write enable, index, 25-bit data   -
//
// One item per cycle sustained while m_axis_tready stays high; each item passes
// the input register, then the result register. The per-item step is one pass of
// compares and two 32-bit subtractions against the state registers.
// Reset clears all control and key/screen state; debounce_ms resets to 10.
// A stalled result holds; s_axis_tready drops only while both registers are
// full and m_axis_tready is low.
module keypad_event_screen_saver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [kes_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // key_sample, now_ms, zero pad
	input  logic [kes_pkg::OP_W-1:0]          s_axis_tuser,  // operation
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [kes_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // key_event, text_on, light_on,
	                                                         // saver_active, zero pad
	input  logic                              cfg_we,
	input  logic [kes_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [kes_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import kes_pkg::*;

	kes_cfg_t             cfg_q;
	kes_state_t           state_q;
	kes_state_t           state_nxt;
	kes_result_t          step_result;
	kes_result_t          result_q;
	logic                 out_valid_q;

	logic                 valid_s1;
	logic [OP_W-1:0]      op_s1;
	logic [SAMPLE_W-1:0]  sample_s1;
	logic [TIME_W-1:0]    now_s1;

	logic                 advance;

	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, result_q.saver_active, result_q.light_on,
		result_q.text_on, result_q.key_event};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms  <= '0;
			cfg_q.saver_mode  <= '0;
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT:  cfg_q.timeout_ms  <= cfg_wdata[TIMEOUT_W-1:0];
				CFG_MODE:     cfg_q.saver_mode  <= cfg_wdata[MODE_W-1:0];
				CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata[DEBOUNCE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1     <= s_axis_tuser;
			sample_s1 <= s_axis_tdata[SAMPLE_W-1:0];
			now_s1    <= s_axis_tdata[SAMPLE_W +: TIME_W];
		end
		if (advance)
			result_q <= step_result;
	end

	kes_step u_step (
		.cfg        (cfg_q),
		.state_cur  (state_q),
		.operation  (op_s1),
		.key_sample (sample_s1),
		.now_ms     (now_s1),
		.state_nxt  (state_nxt),
		.result     (step_result)
	);

endmodule

// File: design/kes_checker.sv
module kes_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [kes_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import kes_pkg::*;

	// output stays put while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input side only backs up when the result side is full and stalled
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a blanked screen never has the backlight on
	a_saver_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6] |-> !m_axis_tdata[5])
		else $error("saver active with light on");

	// key events stay within -5..+5
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] != 4'd6 && m_axis_tdata[3:0] != 4'd7 &&
			m_axis_tdata[3:0] != 4'd8 && m_axis_tdata[3:0] != 4'd9 &&
			m_axis_tdata[3:0] != 4'd10)
		else $error("key event out of range");

endmodule

bind keypad_event_screen_saver kes_checker u_kes_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/keypad_event_screen_saver_checker.sv
module keypad_event_screen_saver_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic [kes_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // key_sample, now_ms, zero pad
	input  logic [kes_pkg::OP_W-1:0]           s_axis_tuser,  // operation
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [kes_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // key_event, text_on, light_on,
	                                                          // saver_active, zero pad
	input  logic                               cfg_we,
	input  logic [kes_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [kes_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output int                                 mismatches,
	output int                                 outstanding
);

	import kes_pkg::*;

	// keypad and display state as the block should hold it
	logic [KEY_W-1:0]      held;
	logic [KEY_W-1:0]      last_read;
	logic [TIME_W-1:0]     read_since;
	logic [TIME_W-1:0]     last_active;
	logic                  eat_release;
	logic                  blanked;
	logic                  text_en;
	logic                  light_en;
	logic                  woke_once;

	logic [TIMEOUT_W-1:0]  idle_limit;
	logic [MODE_W-1:0]     blank_mode;
	logic [DEBOUNCE_W-1:0] settle_ms;

	logic [KEY_W-1:0]      ladder [KEY_TABLE_ENTRIES];
	kes_result_t           screen_events_q [$];
	int                    fail_total;

	assign mismatches = fail_total;

	initial begin
		ladder = '{KEY_RIGHT, KEY_NONE, KEY_NONE, KEY_NONE, KEY_UP, KEY_NONE, KEY_NONE,
			KEY_NONE, KEY_NONE, KEY_DOWN, KEY_DOWN, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE,
			KEY_LEFT, KEY_LEFT, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE,
			KEY_SELECT, KEY_SELECT, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE,
			KEY_NONE, KEY_NONE, KEY_NONE};
	end

	function automatic void wake_display(input logic [TIME_W-1:0] now);
		text_en     = 1'b1;
		light_en    = 1'b1;
		blanked     = 1'b0;
		woke_once   = 1'b1;
		last_active = now;
	endfunction

	function automatic void blank_display();
		if (blank_mode == MODE_TEXT_OFF)
			text_en = 1'b0;
		light_en  = 1'b0;
		blanked   = 1'b1;
		woke_once = 1'b1;
	endfunction

	function automatic logic signed [EVENT_W-1:0] poll_keypad(
		input logic [SAMPLE_W-1:0] sample,
		input logic [TIME_W-1:0]   now
	);
		logic [KEY_W-1:0]  reading;
		logic [KEY_W-1:0]  released;
		logic [TIME_W-1:0] stable_for;
		logic [TIME_W-1:0] idle_for;
		if (!woke_once)
			wake_display(now);
		reading = ladder[sample[SAMPLE_W-1 -: KEY_IDX_W]];
		if (reading != last_read)
			read_since = now;
		last_read  = reading;
		stable_for = now - read_since;
		if (stable_for < TIME_W'(settle_ms))
			reading = held;

		if (held == KEY_NONE && reading != KEY_NONE) begin
			held = reading;
			if (blanked) begin
				if (blank_mode == MODE_SELECT_WAKE) begin
					// only select brings the light back; text untouched
					if (reading == KEY_SELECT) begin
						light_en  = 1'b1;
						blanked   = 1'b0;
						woke_once = 1'b1;
					end
				end else if (blank_mode == MODE_TEXT_OFF) begin
					wake_display(now);
					eat_release = 1'b1;
					return '0;
				end else begin
					wake_display(now);
				end
			end else if (blank_mode == MODE_SELECT_WAKE && reading != KEY_SELECT) begin
				// reported, but the idle timer keeps running
				eat_release = 1'b0;
				return $signed({1'b0, reading});
			end
			eat_release = 1'b0;
			last_active = now;
			return $signed({1'b0, reading});
		end

		if (held != KEY_NONE && reading == KEY_NONE) begin
			released    = held;
			held        = KEY_NONE;
			last_active = now;
			if (eat_release) begin
				eat_release = 1'b0;
				return '0;
			end
			return -$signed({1'b0, released});
		end

		idle_for = now - last_active;
		if (!blanked && held == KEY_NONE && idle_limit != '0 &&
		    idle_for >= TIME_W'(idle_limit))
			blank_display();
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		logic signed [EVENT_W-1:0] ev;
		logic signed [EVENT_W-1:0] got_event;
		logic                      got_text;
		logic                      got_light;
		logic                      got_saver;
		kes_result_t               want;
		kes_result_t               fresh;
		if (!arst_n) begin
			held        = KEY_NONE;
			last_read   = KEY_NONE;
			read_since  = '0;
			last_active = '0;
			eat_release = 1'b0;
			blanked     = 1'b0;
			text_en     = 1'b0;
			light_en    = 1'b0;
			woke_once   = 1'b0;
			idle_limit  = '0;
			blank_mode  = MODE_TEXT_OFF;
			settle_ms   = DEBOUNCE_RESET;
			screen_events_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT:  idle_limit = cfg_wdata[TIMEOUT_W-1:0];
					CFG_MODE:     blank_mode = cfg_wdata[MODE_W-1:0];
					CFG_DEBOUNCE: settle_ms  = cfg_wdata[DEBOUNCE_W-1:0];
					default: ;
				endcase
			end

			// results leave through the input and result registers after their input, so retire first
			if (m_axis_tvalid && m_axis_tready) begin
				got_event = m_axis_tdata[EVENT_W-1:0];
				got_text  = m_axis_tdata[EVENT_W];
				got_light = m_axis_tdata[EVENT_W+1];
				got_saver = m_axis_tdata[EVENT_W+2];
				if (screen_events_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: unexpected result event %0d text %0b light %0b saver %0b",
							$time, got_event, got_text, got_light, got_saver);
				end else begin
					want = screen_events_q.pop_front();
					if (want.key_event !== got_event || want.text_on !== got_text ||
					    want.light_on !== got_light || want.saver_active !== got_saver) begin
						fail_total++;
						if (fail_total <= 10)
							$display("%0t: mismatch: exp ev %0d t %0b l %0b s %0b, got ev %0d t %0b l %0b s %0b",
								$time, want.key_event, want.text_on, want.light_on,
								want.saver_active, got_event, got_text, got_light, got_saver);
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				ev = '0;
				case (s_axis_tuser)
					OP_POLL:    ev = poll_keypad(s_axis_tdata[SAMPLE_W-1:0],
						s_axis_tdata[SAMPLE_W +: TIME_W]);
					OP_RESTORE: wake_display(s_axis_tdata[SAMPLE_W +: TIME_W]);
					OP_BLANK:   blank_display();
					default: ;
				endcase
				fresh.key_event    = ev;
				fresh.text_on      = text_en;
				fresh.light_on     = light_en;
				fresh.saver_active = blanked;
				screen_events_q.push_back(fresh);
			end
			outstanding <= screen_events_q.size();
		end
	end

endmodule

// File: tb/sv/keypad_event_screen_saver_test.sv
module keypad_event_screen_saver_test;

	import kes_pkg::*;

	localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = 25'd32767000;

	// ladder readings on each key position
	localparam logic [SAMPLE_W-1:0] SAMPLE_RIGHT  = 10'd0;
	localparam logic [SAMPLE_W-1:0] SAMPLE_UP     = 10'd150;
	localparam logic [SAMPLE_W-1:0] SAMPLE_DOWN   = 10'd300;
	localparam logic [SAMPLE_W-1:0] SAMPLE_LEFT   = 10'd500;
	localparam logic [SAMPLE_W-1:0] SAMPLE_SELECT = 10'd740;
	localparam logic [SAMPLE_W-1:0] SAMPLE_OPEN   = 10'd1023;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int HOLD_CYCLES     = 300;
	localparam int CYCLE_LIMIT     = 400000;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;  // key_sample, now_ms, zero pad
	logic [OP_W-1:0]        s_axis_tuser  = '0;  // operation
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;        // key_event, text_on, light_on,
	                                             // saver_active, zero pad
	logic                   cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

	int mismatches;
	int outstanding;
	int hold_requests = 0;
	int holds_done    = 0;
	int settle_now    = int'(DEBOUNCE_RESET);

	keypad_event_screen_saver uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	keypad_event_screen_saver_checker event_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always #10 clk = ~clk;

	// table positions that decode to a key
	function automatic logic [KEY_IDX_W-1:0] keyed_slot(input int n);
		case (n)
			0:       return SAMPLE_RIGHT[SAMPLE_W-1 -: KEY_IDX_W];
			1:       return SAMPLE_UP[SAMPLE_W-1 -: KEY_IDX_W];
			2:       return SAMPLE_DOWN[SAMPLE_W-1 -: KEY_IDX_W];
			3:       return 5'd10;
			4:       return SAMPLE_LEFT[SAMPLE_W-1 -: KEY_IDX_W];
			5:       return 5'd16;
			6:       return 5'd22;
			default: return SAMPLE_SELECT[SAMPLE_W-1 -: KEY_IDX_W];
		endcase
	endfunction

	// returns at the edge where the transfer happens
	task automatic send_item(
		input logic [OP_W-1:0]     op,
		input logic [SAMPLE_W-1:0] sample,
		input logic [TIME_W-1:0]   now,
		input logic                steady
	);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-SAMPLE_W-TIME_W){1'b0}}, now, sample};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic retune(
		input logic [TIMEOUT_W-1:0]  limit,
		input logic [MODE_W-1:0]     mode,
		input logic [DEBOUNCE_W-1:0] settle
	);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_index <= CFG_MODE;
		cfg_wdata <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_index <= CFG_DEBOUNCE;
		cfg_wdata <= CFG_DATA_W'(settle);
		@(posedge clk);
		cfg_we     <= 1'b0;
		settle_now = int'(settle);
	endtask

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : receiver
		int   stall;
		logic rx_steady;
		rx_steady = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (holds_done < hold_requests) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin : stimulus
		int                    phase;
		int                    n;
		int                    reps;
		int                    pick;
		logic [KEY_IDX_W-1:0]  slot;
		logic [4:0]            fine_bits;
		logic [TIME_W-1:0]     clock_ms;
		logic                  steady;
		logic [OP_W-1:0]       op;
		logic [TIMEOUT_W-1:0]  limit;
		logic [MODE_W-1:0]     mode;
		logic [DEBOUNCE_W-1:0] settle;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no saver timeout, text-off mode, debounce 10
		send_item(OP_POLL, SAMPLE_OPEN, 32'd0, 1'b0);        // first poll restores
		send_item(OP_POLL, SAMPLE_RIGHT, 32'd3, 1'b0);       // still bouncing
		send_item(OP_POLL, SAMPLE_RIGHT, 32'd13, 1'b0);      // press
		send_item(OP_POLL, SAMPLE_OPEN, 32'd14, 1'b0);
		send_item(OP_POLL, SAMPLE_OPEN, 32'd24, 1'b0);       // release
		send_item(OP_UNUSED, SAMPLE_OPEN, 32'hFFFF_FFFF, 1'b0);
		send_item(OP_BLANK, SAMPLE_OPEN, 32'd25, 1'b1);
		send_item(OP_POLL, SAMPLE_SELECT, 32'd30, 1'b1);
		send_item(OP_POLL, SAMPLE_SELECT, 32'd40, 1'b1);     // waking press, swallowed
		send_item(OP_POLL, SAMPLE_OPEN, 32'd41, 1'b0);
		send_item(OP_POLL, SAMPLE_OPEN, 32'd51, 1'b0);       // its release, swallowed
		send_item(OP_RESTORE, SAMPLE_OPEN, 32'hFFFF_FFF0, 1'b0);

		// select-wake mode, idle time wrapping past zero
		retune(25'd100, MODE_SELECT_WAKE, 8'd0);
		send_item(OP_POLL, SAMPLE_OPEN, 32'hFFFF_FFF8, 1'b0);
		send_item(OP_POLL, SAMPLE_OPEN, 32'h0000_005C, 1'b0); // blanks
		send_item(OP_POLL, SAMPLE_UP, 32'h0000_0060, 1'b0);   // reported, stays dark
		send_item(OP_POLL, SAMPLE_OPEN, 32'h0000_0061, 1'b0);
		send_item(OP_POLL, SAMPLE_SELECT, 32'h0000_0062, 1'b0);
		send_item(OP_POLL, SAMPLE_OPEN, 32'h0000_0063, 1'b0);
		send_item(OP_POLL, SAMPLE_LEFT, 32'h0000_0070, 1'b0); // no idle restart
		send_item(OP_POLL, SAMPLE_OPEN, 32'h0000_0080, 1'b0);
		send_item(OP_POLL, SAMPLE_DOWN, 32'h0000_00E7, 1'b0);
		send_item(OP_POLL, SAMPLE_OPEN, 32'h0000_0200, 1'b0);

		clock_ms = $urandom();
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin limit = TIMEOUT_MAX; mode = MODE_TEXT_OFF;    settle = 8'd255; end
				1: begin limit = 25'd1;       mode = MODE_LIGHT_OFF;   settle = 8'd0;   end
				2: begin limit = 25'd0;       mode = MODE_SELECT_WAKE; settle = 8'd3;   end
				3: begin limit = 25'd60;      mode = MODE_UNUSED;      settle = 8'd12;  end
				default: begin
					case ($urandom_range(0, 3))
						0:       limit = '0;
						1:       limit = TIMEOUT_W'($urandom_range(1, 200));
						2:       limit = TIMEOUT_W'($urandom_range(0, TIMEOUT_MAX));
						default: limit = TIMEOUT_W'($urandom_range(1, 30));
					endcase
					mode   = MODE_W'($urandom_range(0, 3));
					settle = ($urandom_range(0, 5) == 0) ? 8'd255 :
						DEBOUNCE_W'($urandom_range(0, 30));
				end
			endcase
			retune(limit, mode, settle);
			// fill the block against a stalled receiver
			if (phase == 2)
				hold_requests++;

			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				steady = ($urandom_range(0, 3) == 0) || (phase == 2 && n < 100);
				if ($urandom_range(0, 11) == 0) begin
					pick = $urandom_range(0, 2);
					op = (pick == 0) ? OP_RESTORE : (pick == 1) ? OP_BLANK : OP_UNUSED;
					clock_ms += $urandom_range(0, settle_now + 4);
					send_item(op, SAMPLE_W'($urandom_range(0, 1023)), clock_ms, steady);
					n++;
				end else begin
					// a run of polls on one ladder position
					slot = $urandom_range(0, 1) ? keyed_slot($urandom_range(0, 7))
						: KEY_IDX_W'($urandom_range(0, 31));
					reps = $urandom_range(1, 6);
					repeat (reps) begin
						pick = $urandom_range(0, 19);
						if (pick == 0)
							clock_ms += $urandom();
						else if (pick == 1)
							clock_ms += $urandom_range(0, 300);
						else
							clock_ms += $urandom_range(0, settle_now + 4);
						fine_bits = 5'($urandom_range(0, 31));
						send_item(OP_POLL, {slot, fine_bits}, clock_ms, steady);
						n++;
					end
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
